// ===== src/lrt_pkg.sv =====
// Shared widths, status codes and divider types for the layer reflectivity block.
package lrt_pkg;
   localparam int unsigned FIELD_W = 14;
   localparam int unsigned DEPTH_W = 16;
   localparam int unsigned TIME_W = 32;
   localparam int unsigned COEF_W = 21;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned MUL_X_W = 32;
   localparam int unsigned MUL_Y_W = 16;
   localparam int unsigned PROD_W = MUL_X_W + MUL_Y_W;
   localparam int unsigned DVD_W = 66;
   localparam int unsigned DVS_W = 46;
   localparam int unsigned DIV_CNT_W = 7;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ZERO_DIV = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT = 2'd2;

   typedef struct packed {
      logic start;
      logic [DVD_W-1:0] dividend;
      logic [DVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic done;
      logic [DVD_W-1:0] quotient;
   } div_rsp_type;
endpackage

// ===== src/lrt_mul.sv =====
// Shared signed multiplier with a registered product.
module lrt_mul (
   input  logic clock,
   input  logic signed [lrt_pkg::MUL_X_W-1:0] mul_x,
   input  logic signed [lrt_pkg::MUL_Y_W-1:0] mul_y,
   output logic signed [lrt_pkg::PROD_W-1:0] prod_ff
);
   always_ff @(posedge clock) begin
      prod_ff <= lrt_pkg::PROD_W'(mul_x * mul_y);
   end
endmodule

// ===== src/lrt_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
module lrt_div (
   input  logic clock,
   input  logic reset,
   input  lrt_pkg::div_req_type div_req,
   output lrt_pkg::div_rsp_type div_rsp
);
   logic [lrt_pkg::DVS_W-1:0] rem_ff;
   logic [lrt_pkg::DVD_W-1:0] dvd_ff;
   logic [lrt_pkg::DVD_W-1:0] quo_ff;
   logic [lrt_pkg::DVS_W-1:0] dvs_ff;
   logic [lrt_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic busy_ff;
   logic done_ff;
   logic [lrt_pkg::DVS_W:0] trial;
   logic ge;

   assign trial = {rem_ff, dvd_ff[lrt_pkg::DVD_W-1]};
   assign ge = trial >= {1'b0, dvs_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= lrt_pkg::DIV_CNT_W'(lrt_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == lrt_pkg::DIV_CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         rem_ff <= '0;
         dvd_ff <= div_req.dividend;
         dvs_ff <= div_req.divisor;
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= ge ? lrt_pkg::DVS_W'(trial - {1'b0, dvs_ff}) : trial[lrt_pkg::DVS_W-1:0];
         dvd_ff <= {dvd_ff[lrt_pkg::DVD_W-2:0], 1'b0};
         quo_ff <= {quo_ff[lrt_pkg::DVD_W-2:0], ge};
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quotient = quo_ff;
endmodule

// ===== src/layer_reflectivity_and_traveltime.sv =====
// Top level: layer sequencer for traveltime sums and linearized reflectivity.
// A trace-start layer, or the first layer after reset, gives no word; any other layer runs
// 11 multiplier steps, six divisions on the 66-step divider (each skipped when its velocity
// or contrast sum is zero) and a final step; layers are taken one at a time, only when idle.
// Reset is synchronous and active high; it clears the layer above, both time sums
// and the handshakes, and sets depth_ff to 16.
module layer_reflectivity_and_traveltime (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [13:0] req_p_velocity,
   input  logic [13:0] req_s_velocity,
   input  logic [13:0] req_density,
   input  logic req_trace_start,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [31:0] rsp_pp_time,
   output logic [31:0] rsp_ps_time,
   output logic signed [20:0] rsp_pp_intercept,
   output logic signed [20:0] rsp_pp_gradient,
   output logic signed [20:0] rsp_ps_gradient,
   output logic [1:0] rsp_status,
   input  logic csr_wr_en,
   input  logic [15:0] csr_wr_data
);
   // Multiplier steps. Each product is registered in the multiplier, then stored in mres_ff.
   localparam logic [3:0] M_AR = 4'd0;    // A*R
   localparam logic [3:0] M_ADR = 4'd1;   // Ad*R
   localparam logic [3:0] M_RDA = 4'd2;   // Rd*A
   localparam logic [3:0] M_BDB = 4'd3;   // Bd*B
   localparam logic [3:0] M_RDB = 4'd4;   // Rd*B
   localparam logic [3:0] M_ADAR = 4'd5;  // Ad*A*R
   localparam logic [3:0] M_BDBR = 4'd6;  // Bd*B*R
   localparam logic [3:0] M_RDBB = 4'd7;  // Rd*B*B
   localparam logic [3:0] M_AAR = 4'd8;   // A*A*R
   localparam logic [3:0] M_BDR = 4'd9;   // Bd*R
   localparam logic [3:0] M_LAST = 4'd10;

   // Division slots: three time quotients, then three coefficients.
   localparam logic [2:0] D_PP = 3'd0;
   localparam logic [2:0] D_PS_A = 3'd1;
   localparam logic [2:0] D_PS_B = 3'd2;
   localparam logic [2:0] D_INTERCEPT = 3'd3;
   localparam logic [2:0] D_PP_GRAD = 3'd4;
   localparam logic [2:0] D_PS_GRAD = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MUL, ST_DSTART, ST_DWAIT, ST_FIN
   } state_type;

   typedef struct packed {
      logic sat;
      logic [20:0] value;
   } coef_type;

   state_type state_ff;
   logic [15:0] depth_ff;
   logic [13:0] a1_ff, b1_ff, r1_ff, a2_ff, b2_ff, r2_ff;
   logic have_upper_ff;
   logic [31:0] pp_sum_ff, ps_sum_ff;
   logic [3:0] mstep_ff;
   logic [2:0] didx_ff;
   logic signed [47:0] mres_ff [10];
   logic [65:0] q_ff [6];
   logic [2:0] neg_ff;

   logic signed [15:0] sum_a, sum_b, sum_r, dif_a, dif_b, dif_r;
   logic signed [31:0] mul_x;
   logic signed [15:0] mul_y;
   logic signed [47:0] prod;
   lrt_pkg::div_req_type div_req;
   lrt_pkg::div_rsp_type div_rsp;
   logic coef_zero, time_skip, skip;
   logic signed [49:0] num;
   logic [49:0] mag;
   logic [45:0] den;

   logic [32:0] pp_add;
   logic [66:0] ps_inc;
   logic [67:0] ps_add;
   logic pp_sat, ps_sat, zero_any;
   logic [31:0] pp_new, ps_new;
   coef_type c_int, c_ppg, c_psg;
   logic load_rsp;

   // Sums and differences of the two layers, all non-overflowing in 16 bits.
   assign sum_a = 16'(a2_ff) + 16'(a1_ff);
   assign sum_b = 16'(b2_ff) + 16'(b1_ff);
   assign sum_r = 16'(r2_ff) + 16'(r1_ff);
   assign dif_a = 16'(a2_ff) - 16'(a1_ff);
   assign dif_b = 16'(b2_ff) - 16'(b1_ff);
   assign dif_r = 16'(r2_ff) - 16'(r1_ff);

   always_comb begin
      mul_x = '0;
      mul_y = '0;
      case (mstep_ff)
         M_AR: begin mul_x = 32'(sum_a); mul_y = sum_r; end
         M_ADR: begin mul_x = 32'(dif_a); mul_y = sum_r; end
         M_RDA: begin mul_x = 32'(dif_r); mul_y = sum_a; end
         M_BDB: begin mul_x = 32'(dif_b); mul_y = sum_b; end
         M_RDB: begin mul_x = 32'(dif_r); mul_y = sum_b; end
         M_ADAR: begin mul_x = 32'(mres_ff[M_AR]); mul_y = dif_a; end
         M_BDBR: begin mul_x = 32'(mres_ff[M_BDB]); mul_y = sum_r; end
         M_RDBB: begin mul_x = 32'(mres_ff[M_RDB]); mul_y = sum_b; end
         M_AAR: begin mul_x = 32'(mres_ff[M_AR]); mul_y = sum_a; end
         M_BDR: begin mul_x = 32'(dif_b); mul_y = sum_r; end
         default: begin mul_x = '0; mul_y = '0; end
      endcase
   end

   lrt_mul u_mul (.clock(clock), .mul_x(mul_x), .mul_y(mul_y), .prod_ff(prod));

   assign coef_zero = (sum_a == 16'sd0) || (sum_b == 16'sd0) || (sum_r == 16'sd0);

   // Numerators and denominators of the three contrast fractions.
   always_comb begin
      num = '0;
      den = '0;
      case (didx_ff)
         D_INTERCEPT: begin
            num = 50'(mres_ff[M_ADR]) + 50'(mres_ff[M_RDA]);
            den = 46'(mres_ff[M_AR]);
         end
         D_PP_GRAD: begin
            num = 50'(mres_ff[M_ADAR]) - (50'(mres_ff[M_BDBR]) <<< 3)
                  - (50'(mres_ff[M_RDBB]) <<< 2);
            den = 46'(mres_ff[M_AAR]);
         end
         D_PS_GRAD: begin
            num = (50'(mres_ff[M_BDR]) <<< 2) + 50'(mres_ff[M_RDA])
                  + (50'(mres_ff[M_RDB]) <<< 1);
            den = 46'(mres_ff[M_AR]);
         end
         default: begin num = '0; den = '0; end
      endcase
   end
   assign mag = num[49] ? 50'(-num) : 50'(num);

   always_comb begin
      div_req.dividend = '0;
      div_req.divisor = '0;
      time_skip = 1'b0;
      case (didx_ff)
         D_PP: begin
            div_req.dividend = 66'({depth_ff, 21'd0}) + 66'(a1_ff >> 1);
            div_req.divisor = 46'(a1_ff);
            time_skip = (a1_ff == '0);
         end
         D_PS_A: begin
            div_req.dividend = 66'({depth_ff, 20'd0}) + 66'(a1_ff >> 1);
            div_req.divisor = 46'(a1_ff);
            time_skip = (a1_ff == '0);
         end
         D_PS_B: begin
            div_req.dividend = 66'({depth_ff, 20'd0}) + 66'(b1_ff >> 1);
            div_req.divisor = 46'(b1_ff);
            time_skip = (b1_ff == '0);
         end
         default: begin
            div_req.dividend = {mag[49:0], 16'd0} + 66'(den >> 1);
            div_req.divisor = den;
         end
      endcase
      skip = (didx_ff >= D_INTERCEPT) ? coef_zero : time_skip;
      div_req.start = (state_ff == ST_DSTART) && !skip;
   end

   lrt_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // Rounded magnitude to signed Q4.16 with clamping.
   function automatic coef_type to_coef(input logic [65:0] quot, input logic neg);
      coef_type c;
      if (neg) begin
         c.sat = quot > 66'd1048576;
         c.value = c.sat ? 21'h100000 : 21'(-quot[20:0]);
      end else begin
         c.sat = quot > 66'd1048575;
         c.value = c.sat ? 21'h0FFFFF : quot[20:0];
      end
      return c;
   endfunction

   // Time sums saturate at all ones; a zero velocity above leaves an all-ones quotient.
   always_comb begin
      pp_add = 33'(pp_sum_ff) + 33'(q_ff[D_PP][31:0]);
      pp_sat = (q_ff[D_PP][65:32] != '0) || pp_add[32];
      pp_new = pp_sat ? '1 : pp_add[31:0];
      ps_inc = 67'(q_ff[D_PS_A]) + 67'(q_ff[D_PS_B]);
      ps_add = 68'(ps_sum_ff) + 68'(ps_inc[31:0]);
      ps_sat = (ps_inc[66:32] != '0) || ps_add[32];
      ps_new = ps_sat ? '1 : ps_add[31:0];
      c_int = to_coef(q_ff[D_INTERCEPT], neg_ff[0]);
      c_ppg = to_coef(q_ff[D_PP_GRAD], neg_ff[1]);
      c_psg = to_coef(q_ff[D_PS_GRAD], neg_ff[2]);
      if (coef_zero) begin
         c_int = '0;
         c_ppg = '0;
         c_psg = '0;
      end
      zero_any = coef_zero || (a1_ff == '0) || (b1_ff == '0);
   end

   // The result word lives in its own output register. The sequencer only waits
   // in ST_FIN when the word before is still unread, so a new layer can be taken
   // while a word waits.
   assign load_rsp = (state_ff == ST_FIN) && (!rsp_valid || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         depth_ff <= 16'd16;
         have_upper_ff <= 1'b0;
         a1_ff <= '0;
         b1_ff <= '0;
         r1_ff <= '0;
         pp_sum_ff <= '0;
         ps_sum_ff <= '0;
         mstep_ff <= '0;
         didx_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            depth_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  a2_ff <= req_p_velocity;
                  b2_ff <= req_s_velocity;
                  r2_ff <= req_density;
                  if (req_trace_start || !have_upper_ff) begin
                     // New trace: this layer becomes the layer above.
                     a1_ff <= req_p_velocity;
                     b1_ff <= req_s_velocity;
                     r1_ff <= req_density;
                     pp_sum_ff <= '0;
                     ps_sum_ff <= '0;
                     have_upper_ff <= 1'b1;
                  end else begin
                     mstep_ff <= '0;
                     state_ff <= ST_MUL;
                  end
               end
            end
            ST_MUL: begin
               if (mstep_ff != M_AR) begin
                  mres_ff[mstep_ff - 4'd1] <= prod;
               end
               mstep_ff <= mstep_ff + 4'd1;
               if (mstep_ff == M_LAST) begin
                  didx_ff <= D_PP;
                  state_ff <= ST_DSTART;
               end
            end
            ST_DSTART: begin
               if (didx_ff >= D_INTERCEPT) begin
                  neg_ff[2'(didx_ff - D_INTERCEPT)] <= num[49];
               end
               if (skip) begin
                  q_ff[didx_ff] <= '1;
                  didx_ff <= didx_ff + 3'd1;
                  state_ff <= (didx_ff == D_PS_GRAD) ? ST_FIN : ST_DSTART;
               end else begin
                  state_ff <= ST_DWAIT;
               end
            end
            ST_DWAIT: begin
               if (div_rsp.done) begin
                  q_ff[didx_ff] <= div_rsp.quotient;
                  didx_ff <= didx_ff + 3'd1;
                  state_ff <= (didx_ff == D_PS_GRAD) ? ST_FIN : ST_DSTART;
               end
            end
            ST_FIN: begin
               if (load_rsp) begin
                  pp_sum_ff <= pp_new;
                  ps_sum_ff <= ps_new;
                  a1_ff <= a2_ff;
                  b1_ff <= b2_ff;
                  r1_ff <= r2_ff;
                  rsp_pp_time <= pp_new;
                  rsp_ps_time <= ps_new;
                  rsp_pp_intercept <= c_int.value;
                  rsp_pp_gradient <= c_ppg.value;
                  rsp_ps_gradient <= c_psg.value;
                  if (zero_any) begin
                     rsp_status <= lrt_pkg::STATUS_ZERO_DIV;
                  end else if (pp_sat || ps_sat || c_int.sat || c_ppg.sat || c_psg.sat) begin
                     rsp_status <= lrt_pkg::STATUS_SAT;
                  end else begin
                     rsp_status <= lrt_pkg::STATUS_OK;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
endmodule

// ===== src/lrt_checker.sv =====
// Port-level checks for the layer reflectivity block, bound to the top level.
module lrt_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [1:0] rsp_status
);
   // A word stays offered until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid) else $error("result word dropped");

   // A waiting word keeps its status.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_status)) else $error("result word changed");

   // When no word is offered, an accepted layer brings none in the cycle after it is taken.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && rsp_valid == 1'b0 |=> !rsp_valid) else $error("result too early");

   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == lrt_pkg::STATUS_OK || rsp_status == lrt_pkg::STATUS_ZERO_DIV
                     || rsp_status == lrt_pkg::STATUS_SAT)) else $error("bad status");
endmodule

bind layer_reflectivity_and_traveltime lrt_checker u_lrt_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid),
   .rsp_ready(rsp_ready),
   .rsp_status(rsp_status)
);

// ===== tb/layer_reflectivity_and_traveltime_checker.sv =====
// Checker for the layer reflectivity block: predicts each result word and compares it.
module layer_reflectivity_and_traveltime_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [13:0] req_p_velocity,
   input  logic [13:0] req_s_velocity,
   input  logic [13:0] req_density,
   input  logic req_trace_start,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic [31:0] rsp_pp_time,
   input  logic [31:0] rsp_ps_time,
   input  logic signed [20:0] rsp_pp_intercept,
   input  logic signed [20:0] rsp_pp_gradient,
   input  logic signed [20:0] rsp_ps_gradient,
   input  logic [1:0] rsp_status,
   input  logic csr_wr_en,
   input  logic [15:0] csr_wr_data,
   output int mismatches,
   output int pending,
   output int interfaces_seen,
   output int zero_div_seen,
   output int saturated_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [lrt_pkg::TIME_W-1:0] pp_time;
      logic [lrt_pkg::TIME_W-1:0] ps_time;
      logic [lrt_pkg::COEF_W-1:0] pp_intercept;
      logic [lrt_pkg::COEF_W-1:0] pp_gradient;
      logic [lrt_pkg::COEF_W-1:0] ps_gradient;
      logic [lrt_pkg::STATUS_W-1:0] status;
   } interface_word_type;

   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   interface_word_type expected_words[$];
   logic [lrt_pkg::DEPTH_W-1:0] layer_thickness;
   logic [lrt_pkg::FIELD_W-1:0] above_p, above_s, above_rho;
   logic [lrt_pkg::TIME_W-1:0] pp_clock, ps_clock;
   bit above_valid;

   // Half-up rounded time quotient; a zero velocity gives all ones.
   function automatic logic [63:0] travel_quotient(logic [63:0] num, logic [63:0] den,
                                                   inout bit zero);
      if (den == 0) begin
         zero = 1;
         return ALL_ONES;
      end
      return (num + (den >> 1)) / den;
   endfunction

   function automatic logic [lrt_pkg::TIME_W-1:0] add_time(
         logic [lrt_pkg::TIME_W-1:0] total, logic [63:0] inc, inout bit sat);
      logic [63:0] t;
      if (inc > 64'hFFFF_FFFF) begin
         sat = 1;
         return '1;
      end
      t = {32'd0, total} + inc;
      if (t > 64'hFFFF_FFFF) begin
         sat = 1;
         return '1;
      end
      return t[lrt_pkg::TIME_W-1:0];
   endfunction

   // Fraction scaled to Q4.16, rounded half away from zero, then clamped.
   function automatic logic [lrt_pkg::COEF_W-1:0] contrast_q416(longint num,
                                                               logic [63:0] den,
                                                               inout bit sat);
      logic [63:0] mag, q, r, v;
      longint s;
      mag = (num < 0) ? 64'(-num) : 64'(num);
      q = mag / den;
      r = mag % den;
      if (q >= 32) v = 64'd1 << 25;
      else v = (q << 16) + (((r << 16) + (den >> 1)) / den);
      s = (num < 0) ? -longint'(v) : longint'(v);
      if (s > 1048575) begin
         sat = 1;
         s = 1048575;
      end else if (s < -1048576) begin
         sat = 1;
         s = -1048576;
      end
      return s[lrt_pkg::COEF_W-1:0];
   endfunction

   task automatic predict_interface(logic [lrt_pkg::FIELD_W-1:0] a2,
                                    logic [lrt_pkg::FIELD_W-1:0] b2,
                                    logic [lrt_pkg::FIELD_W-1:0] r2, logic start);
      interface_word_type w;
      bit zero, sat;
      logic [63:0] d, q1, q2, inc;
      longint a1, b1, r1, A, B, R, Ad, Bd, Rd;
      zero = 0;
      sat = 0;
      if (start || !above_valid) begin
         pp_clock = '0;
         ps_clock = '0;
         above_p = a2;
         above_s = b2;
         above_rho = r2;
         above_valid = 1;
         return;
      end
      a1 = above_p;
      b1 = above_s;
      r1 = above_rho;
      d = 64'(layer_thickness);
      inc = travel_quotient(d << 21, 64'(a1), zero);
      pp_clock = add_time(pp_clock, inc, sat);
      q1 = travel_quotient(d << 20, 64'(a1), zero);
      q2 = travel_quotient(d << 20, 64'(b1), zero);
      inc = (q1 == ALL_ONES || q2 == ALL_ONES) ? ALL_ONES : q1 + q2;
      ps_clock = add_time(ps_clock, inc, sat);
      A = a2 + a1;
      B = b2 + b1;
      R = r2 + r1;
      Ad = longint'(a2) - a1;
      Bd = longint'(b2) - b1;
      Rd = longint'(r2) - r1;
      w.pp_intercept = '0;
      w.pp_gradient = '0;
      w.ps_gradient = '0;
      if (A == 0 || B == 0 || R == 0) begin
         zero = 1;
      end else begin
         w.pp_intercept = contrast_q416(Ad * R + Rd * A, 64'(A * R), sat);
         w.pp_gradient = contrast_q416(Ad * A * R - 8 * Bd * B * R - 4 * Rd * B * B,
                                       64'(R * A * A), sat);
         w.ps_gradient = contrast_q416(4 * Bd * R + Rd * A + 2 * Rd * B,
                                       64'(R * A), sat);
      end
      above_p = a2;
      above_s = b2;
      above_rho = r2;
      w.pp_time = pp_clock;
      w.ps_time = ps_clock;
      w.status = zero ? lrt_pkg::STATUS_ZERO_DIV
                      : (sat ? lrt_pkg::STATUS_SAT : lrt_pkg::STATUS_OK);
      expected_words.push_back(w);
   endtask

   assign pending = expected_words.size();

   always @(posedge clock) begin
      interface_word_type got, want;
      if (reset) begin
         mismatches = 0;
         interfaces_seen = 0;
         zero_div_seen = 0;
         saturated_seen = 0;
         layer_thickness = 16'd16;
         above_p = '0;
         above_s = '0;
         above_rho = '0;
         pp_clock = '0;
         ps_clock = '0;
         above_valid = 0;
         expected_words.delete();
      end else begin
         if (csr_wr_en) layer_thickness = csr_wr_data;
         if (req_valid && req_ready)
            predict_interface(req_p_velocity, req_s_velocity, req_density, req_trace_start);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_pp_time, rsp_ps_time, rsp_pp_intercept, rsp_pp_gradient,
                    rsp_ps_gradient, rsp_status};
            interfaces_seen++;
            if (rsp_status == lrt_pkg::STATUS_ZERO_DIV) zero_div_seen++;
            if (rsp_status == lrt_pkg::STATUS_SAT) saturated_seen++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("%0t: unexpected word %p", $realtime, got);
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: word mismatch\n  expected %p\n  actual   %p",
                              $realtime, want, got);
               end
            end
         end
      end
   end
endmodule

// ===== tb/layer_reflectivity_and_traveltime_test.sv =====
// Testbench top: clock, reset, layer stimulus, receiver stalls and the verdict.
module layer_reflectivity_and_traveltime_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock, reset;
   logic req_valid, req_ready, req_trace_start;
   logic [13:0] req_p_velocity, req_s_velocity, req_density;
   logic rsp_valid, rsp_ready;
   logic [31:0] rsp_pp_time, rsp_ps_time;
   logic signed [20:0] rsp_pp_intercept, rsp_pp_gradient, rsp_ps_gradient;
   logic [1:0] rsp_status;
   logic csr_wr_en;
   logic [15:0] csr_wr_data;
   int mismatches, pending, interfaces_seen, zero_div_seen, saturated_seen;

   // The sender moves in bursts: burst_left words go back to back, then a gap.
   int burst_left;
   int layers_sent;
   int rx_cycle = 0;

   layer_reflectivity_and_traveltime DUT (.*);
   layer_reflectivity_and_traveltime_checker checker_inst (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Every sender input has a known value from time zero.
   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_p_velocity = '0;
      req_s_velocity = '0;
      req_density = '0;
      req_trace_start = 1'b0;
      csr_wr_en = 1'b0;
      csr_wr_data = 16'd16;
   end

   // The receiver stalls on its own pattern, cycling through four moods: always
   // ready, mostly ready, mostly stalled, and a fixed periodic stall.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      case ((rx_cycle / 97) % 4)
         0: begin
            rsp_ready <= 1'b1;
         end
         1: begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         2: begin
            rsp_ready <= ($urandom_range(0, 3) == 0);
         end
         default: begin
            rsp_ready <= ((rx_cycle % 7) < 3);
         end
      endcase
   end

   // Presents one layer word and holds it until the block takes it, then decides
   // whether the next word follows at once or after a random gap. Called at a
   // falling edge and returns at one.
   task automatic send_layer(logic [13:0] p, logic [13:0] s, logic [13:0] rho, logic ts);
      req_valid <= 1'b1;
      req_p_velocity <= p;
      req_s_velocity <= s;
      req_density <= rho;
      req_trace_start <= ts;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      layers_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 40)) @(negedge clock);
         // Some bursts are long so that back-to-back stretches also occur.
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 6);
      end
   endtask

   // Waits until every predicted word has come back, then lets the block settle
   // for longer than one layer can take before the depth register is touched.
   task automatic drain_and_set_depth(logic [15:0] depth);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= depth;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   // One random trace: a trace start, then layers mostly in a plausible range with
   // full-range, tiny and stray trace-start words mixed in.
   task automatic send_trace(int length);
      logic [13:0] p, s, rho;
      logic ts;
      send_layer(14'($urandom_range(1500, 6000)), 14'($urandom_range(0, 3000)),
                 14'($urandom_range(1000, 3000)), 1'b1);
      for (int i = 0; i < length; i++) begin
         ts = 1'b0;
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
               p = 14'($urandom_range(0, 16383));
               s = 14'($urandom_range(0, 16383));
               rho = 14'($urandom_range(0, 16383));
            end
            5, 6: begin
               p = 14'($urandom_range(0, 3));
               s = 14'($urandom_range(0, 3));
               rho = 14'($urandom_range(0, 3));
            end
            7: begin
               p = 14'($urandom_range(0, 16383));
               s = 14'($urandom_range(0, 16383));
               rho = 14'($urandom_range(0, 16383));
               ts = 1'b1;
            end
            default: begin
               p = 14'($urandom_range(1500, 6000));
               s = 14'($urandom_range(0, p / 2 + 200));
               rho = 14'($urandom_range(1000, 3000));
            end
         endcase
         send_layer(p, s, rho, ts);
      end
   endtask

   initial begin
      logic [15:0] depths[5];
      int phase_layers;
      depths = '{16'd65535, 16'd0, 16'd1, 16'd1000, 16'd16};
      burst_left = 0;
      layers_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset depth of 16. The first word arrives with no
      // layer above, so it opens a trace by itself.
      send_layer(14'd1000, 14'd500, 14'd2000, 1'b0);
      send_layer(14'd16383, 14'd16383, 14'd16383, 1'b0);
      send_layer(14'd0, 14'd0, 14'd0, 1'b0);
      // Both layers all zero: every contrast sum is zero and the layer above
      // has zero velocities.
      send_layer(14'd0, 14'd0, 14'd0, 1'b0);
      send_layer(14'd3000, 14'd0, 14'd2500, 1'b0);
      // The layer above has a P velocity but no S velocity.
      send_layer(14'd3000, 14'd1500, 14'd2500, 1'b0);
      // Strong contrasts that push the gradients into saturation.
      send_layer(14'd1, 14'd16383, 14'd1, 1'b0);
      send_layer(14'd16383, 14'd1, 14'd16383, 1'b0);
      send_layer(14'd2000, 14'd1000, 14'd2200, 1'b1);
      // Identical layers give zero contrasts.
      send_layer(14'd2000, 14'd1000, 14'd2200, 1'b0);
      send_layer(14'd5000, 14'd2500, 14'd2400, 1'b0);

      // Thick layers under a near-zero velocity saturate the time sums.
      drain_and_set_depth(16'd65535);
      send_layer(14'd1, 14'd1, 14'd1, 1'b1);
      send_layer(14'd5000, 14'd2500, 14'd2400, 1'b0);
      send_layer(14'd1, 14'd1, 14'd1, 1'b0);
      send_layer(14'd16383, 14'd16383, 14'd16383, 1'b0);

      // Random traces over several thicknesses, including zero, one and the top
      // of the register, plus one random setting.
      depths[3] = 16'($urandom_range(2, 65534));
      foreach (depths[k]) begin
         if (k > 0) drain_and_set_depth(depths[k]);
         phase_layers = 0;
         while (phase_layers < 225) begin
            send_trace($urandom_range(2, 40));
            phase_layers = layers_sent - 15 - 225 * k;
         end
      end

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (500) @(negedge clock);
      $display("Sent %0d layer words over six thickness settings; checked %0d interfaces,",
               layers_sent, interfaces_seen);
      $display("  %0d with a zero divisor and %0d saturated.", zero_div_seen, saturated_seen);
      if (mismatches == 0 && pending == 0) begin
         $display("layer_reflectivity_and_traveltime regression: pass");
      end else begin
         $display("layer_reflectivity_and_traveltime regression: fail");
      end
      $finish;
   end

   // Safety net: a correct run needs well under a quarter of this.
   initial begin
      #40ms;
      $display("layer_reflectivity_and_traveltime regression: fail");
      $finish;
   end
endmodule

// ===== sim.f =====
src/lrt_pkg.sv
src/lrt_mul.sv
src/lrt_div.sv
src/layer_reflectivity_and_traveltime.sv
src/lrt_checker.sv
tb/layer_reflectivity_and_traveltime_checker.sv
tb/layer_reflectivity_and_traveltime_test.sv
